FILE: design/box_ds_pkg.sv
`default_nettype none

package box_ds_pkg;

  // Pixel and sum widths
  localparam int PIX_W   = 8;
  localparam int PAIR_W  = PIX_W + 1;
  localparam int QUAD_W  = PIX_W + 2;

  // Frame geometry
  localparam int MAX_WIDTH   = 1024;
  localparam int MAX_HEIGHT  = 1024;
  localparam int SIZE_W      = 11;
  localparam int CNT_W       = 10;
  localparam int STORE_DEPTH = MAX_WIDTH / 2;
  localparam int ADDR_W      = $clog2(STORE_DEPTH);

  localparam logic [SIZE_W-1:0] MIN_SIZE     = SIZE_W'(2);
  localparam logic [SIZE_W-1:0] WIDTH_LIMIT  = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] HEIGHT_LIMIT = SIZE_W'(MAX_HEIGHT);
  localparam logic [SIZE_W-1:0] WIDTH_RESET  = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RESET = SIZE_W'(480);

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = SIZE_W;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 1'd1;

  // Clamp a configured size into [2, limit]
  function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                   input logic [SIZE_W-1:0] limit);
    logic [SIZE_W-1:0] r;
    if (v < MIN_SIZE) begin
      r = MIN_SIZE;
    end else if (v > limit) begin
      r = limit;
    end else begin
      r = v;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: design/box_ds_if.sv
`default_nettype none

// Source pixel channel
interface box_ds_in_if;
  import box_ds_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_in;

  modport source (output valid, output pixel_in, input ready);
  modport sink (input valid, input pixel_in, output ready);
endinterface

// Downsampled pixel channel
interface box_ds_out_if;
  import box_ds_pkg::*;

  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel_out;
  logic             row_end;
  logic             frame_end;

  modport source (output valid, output pixel_out, output row_end, output frame_end,
                  input ready);
  modport sink (input valid, input pixel_out, input row_end, input frame_end,
                output ready);
endinterface

`default_nettype wire

FILE: design/box_ds_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one registered read port
module box_ds_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: design/box_downsample_2x2.sv
`default_nettype none

// Channel      Dir  Beat payload                          Handshake
// in_stream    in   pixel_in[7:0]                         valid/ready
// out_stream   out  pixel_out[7:0], row_end, frame_end    valid/ready
// cfg          in   cfg_index[0], cfg_data[10:0]          cfg_we, no back-pressure
//
// One pixel per clock unless the output stalls; a block's result goes through the
// read stage (line store read) and then the output register.
// Reset: counters cleared, size 640x480; the line store is not cleared.
// A stalled output holds its beat; input stays ready while the output register
// drains or the read stage is empty.

module box_downsample_2x2 (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_we,
  input  wire logic [box_ds_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [box_ds_pkg::CFG_DATA_W-1:0] cfg_data,
  box_ds_in_if.sink                          in_stream,
  box_ds_out_if.source                       out_stream
);
  import box_ds_pkg::*;

  // Clamped frame size
  logic [SIZE_W-1:0] width_eff;
  logic [SIZE_W-1:0] height_eff;

  // Position and pair state
  logic [CNT_W-1:0] column_count;
  logic [CNT_W-1:0] row_count;
  logic [PIX_W-1:0] pair_sum;

  // Read stage
  logic              stage_valid;
  logic [PAIR_W-1:0] stage_pair;
  logic              stage_row_end;
  logic              stage_frame_end;

  // Output register
  logic             out_valid;
  logic [PIX_W-1:0] out_pixel;
  logic             out_row_end;
  logic             out_frame_end;

  logic               accept;
  logic               out_free;
  logic               stage_move;
  logic [SIZE_W-1:0]  x_ext;
  logic [SIZE_W-1:0]  y_ext;
  logic [SIZE_W-1:0]  idx_ext;
  logic [SIZE_W-1:0]  out_width;
  logic [SIZE_W-1:0]  even_height;
  logic [ADDR_W-1:0]  idx;
  logic               in_frame;
  logic               use_pair;
  logic               store_wr;
  logic               store_rd;
  logic               is_row_end;
  logic               is_frame_end;
  logic [PAIR_W-1:0]  pair;
  logic [PAIR_W-1:0]  store_rd_data;
  logic [QUAD_W-1:0]  quad_sum;
  logic [QUAD_W-1:0]  quad_round;
  logic               row_done;
  logic               frame_done;

  // Handshake
  assign out_free        = !out_valid || out_stream.ready;
  assign in_stream.ready = !stage_valid || out_free;
  assign accept          = in_stream.valid && in_stream.ready;
  assign stage_move      = stage_valid && out_free;

  // Position decode
  assign x_ext       = {1'b0, column_count};
  assign y_ext       = {1'b0, row_count};
  assign idx         = column_count[CNT_W-1:1];
  assign idx_ext     = {2'b00, idx};
  assign out_width   = {1'b0, width_eff[SIZE_W-1:1]};
  assign even_height = {height_eff[SIZE_W-1:1], 1'b0};
  assign in_frame    = (x_ext < width_eff) && (y_ext < height_eff);
  assign use_pair    = in_frame && column_count[0] && (idx_ext < out_width)
                       && (y_ext < even_height);
  assign store_wr    = accept && use_pair && !row_count[0];
  assign store_rd    = accept && use_pair && row_count[0];
  assign pair        = {1'b0, pair_sum} + {1'b0, in_stream.pixel_in};
  assign is_row_end  = (idx_ext == out_width - SIZE_W'(1));
  assign is_frame_end = is_row_end && (y_ext == even_height - SIZE_W'(1));
  assign row_done    = (x_ext + SIZE_W'(1)) >= width_eff;
  assign frame_done  = (y_ext + SIZE_W'(1)) >= height_eff;

  // Line store of even-row pair sums
  box_ds_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (STORE_DEPTH)
  ) u_line_store (
    .clk     (clk),
    .wr_en   (store_wr),
    .wr_addr (idx),
    .wr_data (pair),
    .rd_en   (store_rd),
    .rd_addr (idx),
    .rd_data (store_rd_data)
  );

  // Rounded mean of the block
  assign quad_sum   = {1'b0, store_rd_data} + {1'b0, stage_pair};
  assign quad_round = quad_sum + QUAD_W'(2);

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_eff  <= WIDTH_RESET;
      height_eff <= HEIGHT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:  width_eff  <= clamp_size(cfg_data, WIDTH_LIMIT);
        REG_FRAME_HEIGHT: height_eff <= clamp_size(cfg_data, HEIGHT_LIMIT);
        default: ;
      endcase
    end
  end

  // Column and row counters
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (row_done) begin
        column_count <= '0;
        row_count    <= frame_done ? '0 : row_count + CNT_W'(1);
      end else begin
        column_count <= column_count + CNT_W'(1);
      end
    end
  end

  // Left pixel of the current pair
  always_ff @(posedge clk) begin
    if (rst) begin
      pair_sum <= '0;
    end else if (accept && in_frame && !column_count[0]) begin
      pair_sum <= in_stream.pixel_in;
    end
  end

  // Read stage: waits for line store data
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (store_rd) begin
      stage_valid <= 1'b1;
    end else if (stage_move) begin
      stage_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (store_rd) begin
      stage_pair      <= pair;
      stage_row_end   <= is_row_end;
      stage_frame_end <= is_frame_end;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_move) begin
      out_pixel     <= quad_round[QUAD_W-1:2];
      out_row_end   <= stage_row_end;
      out_frame_end <= stage_frame_end;
    end
  end

  assign out_stream.valid     = out_valid;
  assign out_stream.pixel_out = out_pixel;
  assign out_stream.row_end   = out_row_end;
  assign out_stream.frame_end = out_frame_end;

  // Checks
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid && !stage_valid)
    else $error("pipeline not empty after reset");

  a_no_read_on_stall: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !out_free) |-> !store_rd)
    else $error("line store read while read stage is stalled");

  a_stage_holds: assert property (@(posedge clk) disable iff (rst)
    (stage_valid && !out_free) |=> stage_valid && $stable(stage_pair))
    else $error("read stage lost its item during a stall");

  a_frame_end_row_end: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!out_frame_end || out_row_end))
    else $error("frame end without row end");

  a_no_rw_same_cycle: assert property (@(posedge clk) disable iff (rst)
    !(store_wr && store_rd))
    else $error("line store read and write in one cycle");

endmodule

`default_nettype wire
